// ----- rtl/imh_pkg.sv -----
// package for the indexed min-heap: sizes, codes, record type, state enum
`default_nettype none
package imh_pkg;
   localparam int HEAP_DEPTH  = 64;
   localparam int NUM_SENDERS = 16;
   localparam int NUM_MSG_IDS = 256;
   localparam int SLOT_W  = $clog2(HEAP_DEPTH);
   localparam int COUNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int SND_W   = $clog2(NUM_SENDERS);
   localparam int MID_W   = $clog2(NUM_MSG_IDS);
   localparam int KEY_W   = SND_W + MID_W;
   localparam int KEYS    = NUM_SENDERS * NUM_MSG_IDS;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_UPDATE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_DUPLICATE = 3'd4
   } status_type;

   typedef struct packed {
      logic        deliverable;
      logic [3:0]  proposer;
      logic [31:0] seq;
      logic [7:0]  msg_id;
      logic [3:0]  sender;
   } rec_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_DECIDE,
      S_POP_RD,
      S_POP_WR,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_RD2,
      S_DN_CMP,
      S_DN_SEL,
      S_SWAP2,
      S_TOP_RD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic less;
   } cmp_type;

   function automatic logic [KEY_W-1:0] key_of(input logic [3:0] snd, input logic [7:0] mid);
      logic [SND_W-1:0] s;
      logic [MID_W-1:0] m;
      s = SND_W'(snd % NUM_SENDERS);
      m = MID_W'(mid % NUM_MSG_IDS);
      return {s, m};
   endfunction
endpackage
`default_nettype wire

// ----- rtl/imh_compare.sv -----
// shared record comparator: a before b by seq, then proposer
`default_nettype none
module imh_compare
   import imh_pkg::*;
(
   input  wire rec_type a,
   input  wire rec_type b,
   output cmp_type      result
);
   assign result.less  = (a.seq < b.seq) || ((a.seq == b.seq) && (a.proposer < b.proposer));
endmodule
`default_nettype wire

// ----- rtl/indexed_min_heap_with_key_update.sv -----
// top level: indexed binary min-heap with push, pop and key increase
//
// channel | dir | handshake              | word
// req     | in  | req_tvalid/req_tready  | operation, sender, msg_id, seq, proposer, deliverable
// rsp     | out | rsp_tvalid/rsp_tready  | status, is_empty, count, top record
//
// one word at a time; push climbs one level per parent read, compare and swap, pop and
// increase descend one level per read of both children, compare, select and swap.
// the single heap read port and the one shared comparator set this cost.
// after reset a clearing pass sweeps all 4096 entries of the position table.
// a result waits in the output register until rsp_tready; no new word meanwhile.
`default_nettype none
module indexed_min_heap_with_key_update
   import imh_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [55:0] req_tdata,  // operation, sender, msg_id, seq, proposer, deliverable, pad
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata   // status, is_empty, count, top sender, msg_id, seq,
                                   // proposer, deliverable, pad
);
   rec_type heap_mem [HEAP_DEPTH];
   logic [SLOT_W:0] pos_mem [KEYS];   // msb valid

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   rec_type in_ff, in_in;
   rec_type a_ff, a_in, b_ff, b_in;   // a: current node, b: partner
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0] p_ff, p_in, c_ff, c_in;
   logic [KEY_W-1:0] clr_ff, clr_in;
   status_type st_ff, st_in;
   logic [SLOT_W:0] pos_rd_ff;
   logic [63:0] out_ff, out_in;
   logic rv_ff, rv_in;

   logic h_we; logic [SLOT_W-1:0] h_wa; rec_type h_wd;
   logic [SLOT_W-1:0] h_ra; rec_type h_rd_ff;
   logic p_we; logic [KEY_W-1:0] p_wa; logic [SLOT_W:0] p_wd;
   logic [KEY_W-1:0] p_ra;
   rec_type cmp_a, cmp_b; cmp_type cmp_r;

   imh_compare u_cmp (.a(cmp_a), .b(cmp_b), .result(cmp_r));

   always_ff @(posedge clock) begin
      if (h_we) heap_mem[h_wa] <= h_wd;
      h_rd_ff <= heap_mem[h_ra];
      if (p_we) pos_mem[p_wa] <= p_wd;
      pos_rd_ff <= pos_mem[p_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      op_ff <= op_in; in_ff <= in_in; a_ff <= a_in; b_ff <= b_in;
      p_ff <= p_in; c_ff <= c_in; st_ff <= st_in; out_ff <= out_in;
   end

   logic [SLOT_W-1:0] last_slot, left_c, up_p;
   logic [COUNT_W-1:0] left_w;
   assign last_slot = SLOT_W'(count_ff - COUNT_W'(1));
   assign left_w    = COUNT_W'({p_ff, 1'b1});
   assign left_c    = SLOT_W'(left_w);
   assign up_p      = SLOT_W'((p_ff - SLOT_W'(1)) >> 1);

   always_comb begin
      state_in = state_ff; op_in = op_ff; in_in = in_ff; a_in = a_ff; b_in = b_ff;
      count_in = count_ff; p_in = p_ff; c_in = c_ff; clr_in = clr_ff; st_in = st_ff;
      out_in = out_ff; rv_in = rv_ff;
      h_we = 1'b0; h_wa = p_ff; h_wd = a_ff; h_ra = p_ff;
      p_we = 1'b0; p_wa = key_of(in_ff.sender, in_ff.msg_id); p_wd = '0;
      p_ra = key_of(in_ff.sender, in_ff.msg_id);
      cmp_a = a_ff; cmp_b = b_ff;
      req_tready = 1'b0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            p_we = 1'b1; p_wa = clr_ff; p_wd = '0;
            clr_in = clr_ff + KEY_W'(1);
            if (clr_ff == KEY_W'(KEYS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = !rv_ff;
            if (req_tvalid && !rv_ff) begin
               op_in = op_type'(req_tdata[1:0]);
               in_in = rec_type'({req_tdata[50], req_tdata[49:46], req_tdata[45:14],
                                  req_tdata[13:6], req_tdata[5:2]});
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            h_ra = '0;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            st_in = ST_OK;
            state_in = S_TOP_RD;
            unique case (op_ff)
               OP_PUSH: begin
                  if (count_ff == COUNT_W'(HEAP_DEPTH)) st_in = ST_FULL;
                  else if (pos_rd_ff[SLOT_W]) st_in = ST_DUPLICATE;
                  else begin
                     p_in = last_slot + SLOT_W'(1);
                     a_in = in_ff;
                     h_we = 1'b1; h_wa = SLOT_W'(count_ff); h_wd = in_ff;
                     p_we = 1'b1; p_wd = {1'b1, SLOT_W'(count_ff)};
                     count_in = count_ff + COUNT_W'(1);
                     state_in = (count_ff == '0) ? S_TOP_RD : S_UP_RD;
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else begin
                     p_we = 1'b1; p_wa = key_of(h_rd_ff.sender, h_rd_ff.msg_id);
                     p_wd = '0;
                     state_in = S_POP_RD;
                  end
               end
               OP_UPDATE: begin
                  if (!pos_rd_ff[SLOT_W] ||
                      COUNT_W'(pos_rd_ff[SLOT_W-1:0]) >= count_ff) st_in = ST_NOT_FOUND;
                  else begin
                     p_in = pos_rd_ff[SLOT_W-1:0];
                     a_in = in_ff;
                     h_we = 1'b1; h_wa = pos_rd_ff[SLOT_W-1:0]; h_wd = in_ff;
                     state_in = S_DN_RD;
                  end
               end
               default: ;
            endcase
         end
         S_POP_RD: begin
            h_ra = last_slot;
            count_in = count_ff - COUNT_W'(1);
            state_in = S_POP_WR;
         end
         S_POP_WR: begin
            p_in = '0;
            a_in = h_rd_ff;
            if (count_ff == '0) state_in = S_TOP_RD;
            else begin
               h_we = 1'b1; h_wa = '0; h_wd = h_rd_ff;
               p_we = 1'b1; p_wa = key_of(h_rd_ff.sender, h_rd_ff.msg_id);
               p_wd = {1'b1, SLOT_W'(0)};
               state_in = S_DN_RD;
            end
         end
         S_UP_RD: begin
            h_ra = up_p; c_in = up_p;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            cmp_a = a_ff; cmp_b = h_rd_ff;
            if (cmp_r.less) begin
               h_we = 1'b1; h_wa = c_ff; h_wd = a_ff;
               p_we = 1'b1; p_wa = key_of(a_ff.sender, a_ff.msg_id); p_wd = {1'b1, c_ff};
               b_in = h_rd_ff;
               state_in = S_SWAP2;
            end else state_in = S_TOP_RD;
         end
         S_DN_RD: begin
            if (left_w >= count_ff || p_ff >= SLOT_W'(HEAP_DEPTH / 2)) state_in = S_TOP_RD;
            else begin
               h_ra = left_c; c_in = left_c;
               state_in = S_DN_RD2;
            end
         end
         S_DN_RD2: begin
            b_in = h_rd_ff;
            h_ra = c_ff + SLOT_W'(1);
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            // right child wins only when strictly smaller
            cmp_a = h_rd_ff; cmp_b = b_ff;
            if (COUNT_W'(c_ff) + COUNT_W'(1) < count_ff && cmp_r.less) begin
               b_in = h_rd_ff; c_in = c_ff + SLOT_W'(1);
            end
            state_in = S_DN_SEL;
         end
         S_DN_SEL: begin
            cmp_a = a_ff; cmp_b = b_ff;
            if (cmp_r.less) state_in = S_TOP_RD;
            else begin
               h_we = 1'b1; h_wa = c_ff; h_wd = a_ff;
               p_we = 1'b1; p_wa = key_of(a_ff.sender, a_ff.msg_id); p_wd = {1'b1, c_ff};
               state_in = S_SWAP2;
            end
         end
         S_SWAP2: begin
            h_we = 1'b1; h_wa = p_ff; h_wd = b_ff;
            p_we = 1'b1; p_wa = key_of(b_ff.sender, b_ff.msg_id); p_wd = {1'b1, p_ff};
            p_in = c_ff;
            if (op_ff == OP_PUSH) state_in = (c_ff == '0) ? S_TOP_RD : S_UP_RD;
            else state_in = S_DN_RD;
         end
         S_TOP_RD: begin
            h_ra = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            out_in = '0;
            out_in[2:0]  = st_ff;
            out_in[3]    = (count_ff == '0);
            out_in[10:4] = 7'(count_ff);
            if (count_ff != '0) out_in[59:11] = h_rd_ff;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(HEAP_DEPTH)) else $error("count above depth");
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> rsp_tvalid) else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_tvalid) else $error("result during clear");
endmodule
`default_nettype wire
